FILE: design/assert_macros.svh
// Assertion macros shared by the median filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/wmf_pkg.sv
// Shared types and constants of the window median filter.
package wmf_pkg;

   localparam int KSIZE_DEF     = 3;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int MAX_HEIGHT    = 2048;
   localparam int CFG_W         = 12;
   localparam int PIX_W         = 8;
   localparam int ROW_W         = $clog2(MAX_HEIGHT);
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } wmf_reg_type;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_FLUSH = 1'b1
   } wmf_kind_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             interior;
      logic             frame_end;
   } wmf_meta_type;

endpackage

FILE: design/wmf_ram.sv
// Generic single write port RAM with registered, write-first read.
module wmf_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         // A read of the entry written in the same cycle returns the new data.
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/wmf_sort_cell.sv
// One compare-exchange stage of the odd-even transposition sort chain.
module wmf_sort_cell import wmf_pkg::*; #(
   parameter int N     = 9,
   parameter int PHASE = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [N-1:0][PIX_W-1:0]    in_vals,
   input  wmf_meta_type               in_meta,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [N-1:0][PIX_W-1:0]    out_vals,
   output wmf_meta_type               out_meta
);

   logic                    valid_ff;
   logic [N-1:0][PIX_W-1:0] vals_ff;
   logic [N-1:0][PIX_W-1:0] vals_in;
   wmf_meta_type            meta_ff;

   // The cell takes a new request when empty or when its own one moves on.
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      vals_in = in_vals;
      for (int i = PHASE; i + 1 < N; i += 2) begin
         if (in_vals[i] > in_vals[i+1]) begin
            vals_in[i]   = in_vals[i+1];
            vals_in[i+1] = in_vals[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         vals_ff <= vals_in;
         meta_ff <= in_meta;
      end
   end

   assign out_valid = valid_ff;
   assign out_vals  = vals_ff;
   assign out_meta  = meta_ff;

endmodule

FILE: design/window_median_filter_unit.sv
// Top level of the streaming window median filter.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_kind, req_in_red/green/blue
//   rsp      out        rsp_valid / rsp_ready  rsp_out_red/green/blue, rsp_frame_end
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One request is taken per cycle unless req_ready is low. A result passes through
// the line store read register and then through each sort cell of the chain.
// Each window position has its own copy of the red line store, so all reads
// happen in the same cycle. Stalls on rsp fill the bubbles of the sort chain
// before they reach req_ready. Reset clears the counters, the valid flags and the
// configuration registers only; the line store needs no clearing pass.
`include "assert_macros.svh"

module window_median_filter_unit import wmf_pkg::*; #(
   parameter int KSIZE     = KSIZE_DEF,
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic [PIX_W-1:0] req_in_red,
   input  logic [PIX_W-1:0] req_in_green,
   input  logic [PIX_W-1:0] req_in_blue,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_out_red,
   output logic [PIX_W-1:0] rsp_out_green,
   output logic [PIX_W-1:0] rsp_out_blue,
   output logic             rsp_frame_end,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int HALF  = KSIZE / 2;
   localparam int WIN_N = KSIZE * KSIZE;
   localparam int DEPTH = (KSIZE - 1) * (MAX_WIDTH + 1) + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(DEPTH + 1);
   localparam int SW    = AW + 3;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = CFG_W + 1;

   logic [CFG_W-1:0] frame_width_ff;
   logic [CFG_W-1:0] frame_height_ff;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    pending_ff, pending_in;

   logic [CFG_W-1:0] w_eff;
   logic [CFG_W-1:0] h_eff;
   logic [PW-1:0]    lag;
   logic [PW:0]      pend_inc;
   logic [PW:0]      center;
   logic             is_pix;
   logic             emit;
   logic             accept;
   logic             interior;
   logic             frame_end;
   logic [AW-1:0]    wp;
   logic signed [SW-1:0] base_raw;
   logic signed [SW-1:0] base_mod;
   logic [AW-1:0]    win_addr [WIN_N];

   logic             v1_ff;
   logic             interior1_ff;
   logic             frame_end1_ff;
   logic             ready1;
   logic [3*PIX_W-1:0] center_px;

   logic [WIN_N:0]                  cv;
   logic [WIN_N:0]                  cr;
   logic [WIN_N-1:0][PIX_W-1:0]     cvals [WIN_N+1];
   wmf_meta_type                    cmeta [WIN_N+1];
   wmf_meta_type                    m_out;
   logic [PIX_W-1:0]                median;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (wmf_reg_type'(csr_index))
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data;
         endcase
      end
   end

   always_comb begin
      w_eff = frame_width_ff;
      if (frame_width_ff == '0) begin
         w_eff = CFG_W'(1);
      end else if ({1'b0, frame_width_ff} > CMP_W'(MAX_WIDTH)) begin
         w_eff = CFG_W'(MAX_WIDTH);
      end
      h_eff = frame_height_ff;
      if (frame_height_ff == '0) begin
         h_eff = CFG_W'(1);
      end else if ({1'b0, frame_height_ff} > CMP_W'(MAX_HEIGHT)) begin
         h_eff = CFG_W'(MAX_HEIGHT);
      end
   end

   // Request side: decide on a result and locate the window in the line store.
   assign lag      = PW'(HALF) * PW'(w_eff) + PW'(HALF);
   assign is_pix   = (wmf_kind_type'(req_kind) == KIND_PIXEL);
   assign pend_inc = {1'b0, pending_ff} + (PW+1)'(1);
   assign center   = is_pix ? pend_inc : {1'b0, pending_ff};
   assign accept   = req_valid && req_ready;

   always_comb begin
      if (is_pix) begin
         emit = pend_inc > (PW+1)'(lag);
      end else begin
         emit = (pending_ff != '0) && (in_row_ff == '0) && (in_col_ff == '0);
      end
   end

   assign interior = (CMP_W'(out_row_ff) >= CMP_W'(HALF)) &&
                     (CMP_W'(out_row_ff) + CMP_W'(HALF) < CMP_W'(h_eff)) &&
                     (CMP_W'(out_col_ff) >= CMP_W'(HALF)) &&
                     (CMP_W'(out_col_ff) + CMP_W'(HALF) < CMP_W'(w_eff));
   assign frame_end = (CMP_W'(out_col_ff) + CMP_W'(1) >= CMP_W'(w_eff)) &&
                      (CMP_W'(out_row_ff) + CMP_W'(1) >= CMP_W'(h_eff));

   assign wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
   assign wp        = is_pix ? wr_ptr_in : wr_ptr_ff;

   // The entry of a given age sits at the write pointer minus that age.
   assign base_raw = $signed(SW'(wp)) - $signed(SW'(center));
   assign base_mod = (base_raw < 0) ? base_raw + SW'(DEPTH) : base_raw;

   for (genvar r = 0; r < KSIZE; r++) begin : g_row
      for (genvar c = 0; c < KSIZE; c++) begin : g_col
         localparam int DR = r - HALF;
         localparam int DC = c - HALF;
         logic signed [SW-1:0] off;
         logic signed [SW-1:0] sum;
         assign off = $signed(SW'(DR)) * $signed(SW'({1'b0, w_eff})) + $signed(SW'(DC));
         assign sum = base_mod + off;
         always_comb begin
            if (sum < 0) begin
               win_addr[r*KSIZE+c] = AW'(sum + SW'(DEPTH));
            end else if (sum >= SW'(DEPTH)) begin
               win_addr[r*KSIZE+c] = AW'(sum - SW'(DEPTH));
            end else begin
               win_addr[r*KSIZE+c] = AW'(sum);
            end
         end
         wmf_ram #(
            .DATA_W (PIX_W),
            .DEPTH  (DEPTH)
         ) u_red_store (
            .clock   (clock),
            .wr_en   (accept && is_pix),
            .wr_addr (wr_ptr_ff),
            .wr_data (req_in_red),
            .rd_en   (ready1),
            .rd_addr (win_addr[r*KSIZE+c]),
            .rd_data (cvals[0][r*KSIZE+c])
         );
      end
   end

   wmf_ram #(
      .DATA_W (3*PIX_W),
      .DEPTH  (DEPTH)
   ) u_pixel_store (
      .clock   (clock),
      .wr_en   (accept && is_pix),
      .wr_addr (wr_ptr_ff),
      .wr_data ({req_in_blue, req_in_green, req_in_red}),
      .rd_en   (ready1),
      .rd_addr (AW'(base_mod)),
      .rd_data (center_px)
   );

   // Position counters and the count of pixels not yet output.
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (CMP_W'(in_col_ff) + CMP_W'(1) >= CMP_W'(w_eff)) begin
         in_col_in = '0;
         in_row_in = (CMP_W'(in_row_ff) + CMP_W'(1) >= CMP_W'(h_eff)) ?
                     '0 : in_row_ff + ROW_W'(1);
      end else begin
         in_col_in = in_col_ff + COL_W'(1);
      end
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (CMP_W'(out_col_ff) + CMP_W'(1) >= CMP_W'(w_eff)) begin
         out_col_in = '0;
         out_row_in = (CMP_W'(out_row_ff) + CMP_W'(1) >= CMP_W'(h_eff)) ?
                      '0 : out_row_ff + ROW_W'(1);
      end else begin
         out_col_in = out_col_ff + COL_W'(1);
      end
      pending_in = PW'(center - (PW+1)'(emit));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         wr_ptr_ff  <= '0;
         pending_ff <= '0;
      end else if (accept) begin
         pending_ff <= pending_in;
         if (is_pix) begin
            in_col_ff <= in_col_in;
            in_row_ff <= in_row_in;
            wr_ptr_ff <= wr_ptr_in;
         end
         if (emit) begin
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
         end
      end
   end

   // Read stage: the store outputs hold the window while the stage is stalled.
   assign ready1    = !v1_ff || cr[0];
   assign req_ready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         interior1_ff  <= interior;
         frame_end1_ff <= frame_end;
      end
   end

   assign cv[0]    = v1_ff;
   assign cmeta[0] = '{red:       center_px[PIX_W-1:0],
                       green:     center_px[2*PIX_W-1:PIX_W],
                       blue:      center_px[3*PIX_W-1:2*PIX_W],
                       interior:  interior1_ff,
                       frame_end: frame_end1_ff};

   // Sort chain: WIN_N odd-even transposition stages order the window.
   for (genvar s = 0; s < WIN_N; s++) begin : g_sort
      wmf_sort_cell #(
         .N     (WIN_N),
         .PHASE (s % 2)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[s]),
         .in_ready  (cr[s]),
         .in_vals   (cvals[s]),
         .in_meta   (cmeta[s]),
         .out_valid (cv[s+1]),
         .out_ready (cr[s+1]),
         .out_vals  (cvals[s+1]),
         .out_meta  (cmeta[s+1])
      );
   end

   assign cr[WIN_N] = rsp_ready;
   assign m_out     = cmeta[WIN_N];
   assign median    = cvals[WIN_N][WIN_N/2];

   assign rsp_valid     = cv[WIN_N];
   assign rsp_out_red   = m_out.interior ? median : m_out.red;
   assign rsp_out_green = m_out.interior ? median : m_out.green;
   assign rsp_out_blue  = m_out.interior ? median : m_out.blue;
   assign rsp_frame_end = m_out.frame_end;

   `ASSERT_ALWAYS(a_pending_bound, clock, reset, pending_ff <= PW'(DEPTH))
   `ASSERT_NEXT(a_emit_enters, clock, reset, accept && emit, v1_ff)
   `ASSERT_NEXT(a_idle_flush, clock, reset, accept && !is_pix && (pending_ff == '0), pending_ff == '0)

endmodule
